/* rtl/shared_array_multi_stack_defines.svh */
// Assertion macros used by the checker file.
// Each macro expects clk and rst to be visible where it is used.
`ifndef SHARED_ARRAY_MULTI_STACK_DEFINES_SVH
`define SHARED_ARRAY_MULTI_STACK_DEFINES_SVH

// Same-cycle implication
`define SAMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SAMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sams_pkg.sv */
package sams_pkg;

  // Fixed field widths
  localparam int SEL_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Control from the stack logic to the entry store
  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic value_we;
  } sams_mem_ctl_t;

endpackage

/* rtl/sams_req_if.sv */
// Request channel: one stack operation
interface sams_req_if import sams_pkg::*;;
  logic                     valid;
  logic                     ready;
  opcode_t                  opcode;
  logic [SEL_W-1:0]         stack_select;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output opcode, output stack_select, output push_value,
                  input ready);
  modport sink   (input valid, input opcode, input stack_select, input push_value,
                  output ready);
endinterface

/* rtl/sams_rsp_if.sv */
// Result channel: one result per request
interface sams_rsp_if import sams_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pop_value;
  status_t                  status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface

/* rtl/sams_store.sv */
// Entry store: value and link memories with registered, write-first reads.
// Links of entries never written read as their reset chain (i -> i+1) via a
// fill count, since entries leave the initial free list strictly in order.
module sams_store import sams_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sams_mem_ctl_t         ctl,
  input  logic [$clog2(DEPTH+1)-1:0] rd_ptr,
  input  logic [$clog2(DEPTH+1)-1:0] wr_ptr,
  input  logic [$clog2(DEPTH+1)-1:0] wr_link,
  input  logic [DATA_W-1:0]     wr_value,
  output logic [$clog2(DEPTH+1)-1:0] rd_link,
  output logic [DATA_W-1:0]     rd_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] value_mem [DEPTH];
  logic [PW-1:0]     link_mem  [DEPTH];
  logic [PW-1:0]     fill;

  logic same_addr;
  assign same_addr = (rd_ptr == wr_ptr);

  // Count of entries written at least once
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.link_we && wr_ptr == fill) begin
      fill <= fill + PW'(1);
    end
  end

  // Link memory
  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[wr_ptr[AW-1:0]] <= wr_link;
    end
    if (ctl.rd_en) begin
      if (ctl.link_we && same_addr) begin
        rd_link <= wr_link;
      end else if (rd_ptr >= fill) begin
        rd_link <= rd_ptr + PW'(1);
      end else begin
        rd_link <= link_mem[rd_ptr[AW-1:0]];
      end
    end
  end

  // Value memory
  always_ff @(posedge clk) begin
    if (ctl.value_we) begin
      value_mem[wr_ptr[AW-1:0]] <= wr_value;
    end
    if (ctl.rd_en) begin
      if (ctl.value_we && same_addr) begin
        rd_value <= wr_value;
      end else begin
        rd_value <= value_mem[rd_ptr[AW-1:0]];
      end
    end
  end

endmodule

/* rtl/shared_array_multi_stack.sv */
// Several LIFO stacks sharing one store of DEPTH entries through a free list.
// req (sink): opcode (push/pop), stack_select, push_value; taken on valid & ready.
// rsp (source): pop_value and status (ok, overflow on push, underflow on pop),
//   exactly one result per request, in request order.
// A taken request is held in the operation register, then moves to the result
//   register when rsp is free. Throughput: one request per cycle while rsp is
//   not stalled; the next request's memory address comes from the link read of
//   the previous one, forwarded straight from the link memory's read register.
// A push with no free entry, or to a stack number of STACKS or more, reports
//   overflow and leaves the store alone; a pop of an empty or absent stack
//   reports underflow with pop_value all ones.
// Reset: all stacks empty, free list is entries 0..DEPTH-1 in order; no
//   clearing pass is needed, the block takes requests straight away.
// While rsp is stalled one further request is held internally, then req.ready
//   drops until the stall clears. ready is low during reset.
module shared_array_multi_stack import sams_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int STACKS = 4
) (
  input  logic      clk,
  input  logic      rst,
  sams_req_if.sink  req,
  sams_rsp_if.source rsp
);

  localparam int PW = $clog2(DEPTH + 1);
  localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam logic [PW-1:0] NIL = PW'(DEPTH);

  // Architectural state
  logic [PW-1:0] stack_heads [STACKS];
  logic [PW-1:0] free_head;

  // Operation register (between request and result)
  logic              b_valid;
  opcode_t           b_op;
  logic [SEL_W-1:0]  b_sel;
  logic              b_ok;
  logic [PW-1:0]     b_ptr;
  logic [PW-1:0]     b_head;
  logic [PW-1:0]     b_free;
  logic [DATA_W-1:0] b_push_value;

  // Result register
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  status_t           out_status;

  logic              accept;
  logic              b_fire;
  logic [PW-1:0]     free_next;
  logic [PW-1:0]     head_next;
  logic [DATA_W-1:0] res_value;
  status_t           res_status;
  logic              link_we;
  logic              value_we;
  logic [PW-1:0]     wr_link;

  logic              in_present;
  logic [SW-1:0]     in_idx;
  logic [PW-1:0]     free_a;
  logic [PW-1:0]     head_a;
  logic [PW-1:0]     ptr_a;
  logic              ok_a;

  sams_mem_ctl_t     mem_ctl;
  logic [PW-1:0]     rd_link;
  logic [DATA_W-1:0] rd_value;

  // Handshakes
  assign b_fire    = b_valid && (!out_valid || rsp.ready);
  assign req.ready = !rst && (!b_valid || b_fire);
  assign accept    = req.valid && req.ready;

  // Completion of the held request: state updates and result
  always_comb begin
    free_next  = free_head;
    head_next  = b_head;
    link_we    = 1'b0;
    value_we   = 1'b0;
    wr_link    = b_head;
    res_value  = '0;
    res_status = ST_OK;
    unique case (b_op)
      OP_PUSH: begin
        if (b_ok) begin
          link_we   = 1'b1;
          value_we  = 1'b1;
          free_next = rd_link;
          head_next = b_ptr;
        end else begin
          res_status = ST_OVERFLOW;
        end
      end
      OP_POP: begin
        if (b_ok) begin
          link_we   = 1'b1;
          wr_link   = b_free;
          res_value = rd_value;
          head_next = rd_link;
          free_next = b_ptr;
        end else begin
          res_value  = '1;
          res_status = ST_UNDERFLOW;
        end
      end
    endcase
  end

  // Incoming request: addresses from state, forwarded from the completing one
  assign in_present = 32'(req.stack_select) < 32'(STACKS);
  assign in_idx     = SW'(req.stack_select);
  assign free_a     = b_fire ? free_next : free_head;

  always_comb begin
    if (!in_present) begin
      head_a = NIL;
    end else if (b_fire && b_ok && b_sel == req.stack_select) begin
      head_a = head_next;
    end else begin
      head_a = stack_heads[in_idx];
    end
  end

  assign ptr_a = (req.opcode == OP_PUSH) ? free_a : head_a;
  assign ok_a  = in_present && (ptr_a < NIL);

  // Memory controls
  always_comb begin
    mem_ctl.rd_en    = accept;
    mem_ctl.link_we  = b_fire && link_we;
    mem_ctl.value_we = b_fire && value_we;
  end

  sams_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mem_ctl),
    .rd_ptr   (ptr_a),
    .wr_ptr   (b_ptr),
    .wr_link  (wr_link),
    .wr_value (b_push_value),
    .rd_link  (rd_link),
    .rd_value (rd_value)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      free_head <= '0;
      for (int i = 0; i < STACKS; i++) begin
        stack_heads[i] <= NIL;
      end
    end else begin
      if (accept) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (b_fire) begin
        free_head <= free_next;
        if (b_ok) begin
          stack_heads[SW'(b_sel)] <= head_next;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      b_op         <= req.opcode;
      b_sel        <= req.stack_select;
      b_ok         <= ok_a;
      b_ptr        <= ptr_a;
      b_head       <= head_a;
      b_free       <= free_a;
      b_push_value <= req.push_value;
    end
    if (b_fire) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.pop_value = out_value;
  assign rsp.status    = out_status;

endmodule

/* rtl/sams_checker.sv */
`include "shared_array_multi_stack_defines.svh"

// Port-level checks on the multi-stack
module sams_checker import sams_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [DATA_W-1:0] pop_value,
  input status_t           status
);

  // A stalled result holds
  `SAMS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(pop_value) && $stable(status), "result changed while stalled")

  // Underflow always returns all ones
  `SAMS_ASSERT_IMP(a_underflow_value, rsp_valid && status == ST_UNDERFLOW, pop_value == '1, "underflow without all-ones value")

  // Overflow always returns zero
  `SAMS_ASSERT_IMP(a_overflow_value, rsp_valid && status == ST_OVERFLOW, pop_value == '0, "overflow with non-zero value")

  // A fresh result follows a taken request
  `SAMS_ASSERT_IMP(a_rsp_origin, $rose(rsp_valid), $past(req_valid && req_ready, 2), "result without a request")

endmodule

bind shared_array_multi_stack sams_checker u_sams_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .pop_value (rsp.pop_value),
  .status    (rsp.status)
);
